FILE: hw/rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants for the split-word 64-bit ALU
// Operation codes, widths and the cell-to-cell link structure.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int DataW  = 64;
    localparam int ActW   = 3;
    localparam int CmpW   = 2;
    localparam int NCells = 4;              // 16-bit slices
    localparam int SliceW = DataW / NCells;
    localparam int StepW  = $clog2(DataW + 1);

    typedef enum logic [ActW-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_CMP = 3'd3,
        ACT_DIV = 3'd4,
        ACT_MOD = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_MUL  = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    // Cell-to-cell link: shift bit moving up and borrow from below.
    typedef struct packed {
        logic shift_bit;
        logic borrow;
    } t_link;

    // Control from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/split_word_64bit_alu.sv
// ----------------------------------------------------------------------------
// split_word_64bit_alu: 64-bit integer ALU with restoring division
// Add, subtract, multiply, signed compare, unsigned divide and modulo.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | input     | i_valid / o_ready  | i_action, i_a_value, i_b_value
// out     | output    | o_valid / i_ready  | o_result_value, o_compare_sign
//
// Divide and modulo: load, 64 steps of the divider cell row (one quotient bit
// per cycle), result register; a zero divisor skips the steps. Multiply: load,
// four 64x16 partial products accumulated, result; other actions: load, result.
// One transaction is in flight at a time; the result is held until taken.
// Synchronous active-low reset clears the control state only.
// ----------------------------------------------------------------------------
module split_word_64bit_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [swa_pkg::ActW-1:0]          i_action,
    input  logic signed [swa_pkg::DataW-1:0]  i_a_value,
    input  logic signed [swa_pkg::DataW-1:0]  i_b_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [swa_pkg::DataW-1:0]  o_result_value,
    output logic signed [swa_pkg::CmpW-1:0]   o_compare_sign
);

    swa_pkg::t_state r_state, n_state;
    logic [swa_pkg::StepW-1:0] r_cnt, n_cnt;
    logic [swa_pkg::ActW-1:0] r_act;
    logic [swa_pkg::DataW-1:0] r_a, r_b, r_res, n_res;
    logic [swa_pkg::CmpW-1:0] r_cmp;
    logic [swa_pkg::DataW-1:0] w_quo, w_rem, w_pp;
    logic [swa_pkg::SliceW-1:0] w_bslice;
    swa_pkg::t_cell_ctl w_ctl;
    logic w_acc;
    logic [swa_pkg::CmpW-1:0] w_cmp;

    assign w_acc = i_valid & (r_state == swa_pkg::ST_IDLE);

    // signed compare of the incoming operands
    always_comb begin
        if (i_a_value == i_b_value)    w_cmp = 2'b00;
        else if (i_a_value < i_b_value) w_cmp = 2'b11;
        else                            w_cmp = 2'b01;
    end

    // multiply: one 64x16 partial product per cycle
    assign w_bslice = r_b[r_cnt[1:0]*swa_pkg::SliceW +: swa_pkg::SliceW];
    assign w_pp = (r_a * {{(swa_pkg::DataW-swa_pkg::SliceW){1'b0}}, w_bslice})
                  << (r_cnt[1:0]*swa_pkg::SliceW);

    swa_div_chain u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_dividend (i_a_value),
        .i_divisor  (r_b),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // sequencer: next state and outputs
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        w_ctl   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            swa_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                w_ctl.load = w_acc;
                n_cnt = '0;
                if (w_acc) begin
                    n_state = swa_pkg::ST_DONE;
                    case (i_action)
                        swa_pkg::ACT_ADD: n_res = i_a_value + i_b_value;
                        swa_pkg::ACT_SUB: n_res = i_a_value - i_b_value;
                        swa_pkg::ACT_MUL: begin
                            n_res = '0;
                            n_state = swa_pkg::ST_MUL;
                        end
                        swa_pkg::ACT_CMP: n_res = {{(swa_pkg::DataW-swa_pkg::CmpW){w_cmp[1]}},
                                                   w_cmp};
                        swa_pkg::ACT_DIV, swa_pkg::ACT_MOD: begin
                            n_res = i_a_value;
                            if (i_b_value != '0) n_state = swa_pkg::ST_DIV;
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            swa_pkg::ST_MUL: begin
                n_res = r_res + w_pp;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == swa_pkg::StepW'(swa_pkg::NCells - 1)) n_state = swa_pkg::ST_DONE;
            end
            swa_pkg::ST_DIV: begin
                w_ctl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == swa_pkg::StepW'(swa_pkg::DataW - 1)) n_state = swa_pkg::ST_DONE;
            end
            swa_pkg::ST_DONE: begin
                o_valid = 1'b1;
                if (i_ready) n_state = swa_pkg::ST_IDLE;
            end
            default: n_state = swa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swa_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // payload registers; the divider result is read from the cell row, which holds it
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act <= i_action;
            r_a   <= i_a_value;
            r_b   <= i_b_value;
            r_cmp <= w_cmp;
        end
        r_res <= n_res;
    end

    assign o_result_value = (r_state == swa_pkg::ST_DONE && r_b != '0 &&
                             (r_act == swa_pkg::ACT_DIV || r_act == swa_pkg::ACT_MOD)) ?
                            ((r_act == swa_pkg::ACT_DIV) ? w_quo : w_rem) : r_res;
    assign o_compare_sign = r_cmp;

`ifndef SYNTH
    // result offered only from the done state
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == swa_pkg::ST_DONE) else $error("valid outside done");
    // ready and valid are never high together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    // divide run stays within 64 steps
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == swa_pkg::ST_DIV |-> r_cnt < swa_pkg::StepW'(swa_pkg::DataW))
        else $error("divide counter overrun");
`endif

endmodule

FILE: hw/rtl/swa_div_cell.sv
// ----------------------------------------------------------------------------
// swa_div_cell: one 16-bit slice of the restoring divider
// Holds a slice of the remainder and dividend/quotient registers. Each step
// shifts one bit toward the upper neighbor and forms a trial difference,
// passing the borrow upward.
// ----------------------------------------------------------------------------
module swa_div_cell (
    input  logic                         i_clk,
    input  swa_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_commit,
    input  logic [swa_pkg::SliceW-1:0]   i_dvd_load,
    input  logic [swa_pkg::SliceW-1:0]   i_dvs,
    input  swa_pkg::t_link               i_lo,
    input  logic                         i_rem_in,
    output swa_pkg::t_link               o_hi,
    output logic                         o_rem_out,
    output logic [swa_pkg::SliceW-1:0]   o_rem,
    output logic [swa_pkg::SliceW-1:0]   o_quo
);

    logic [swa_pkg::SliceW-1:0] r_rem, n_rem;
    logic [swa_pkg::SliceW-1:0] r_dq, n_dq;
    logic [swa_pkg::SliceW-1:0] w_sh;
    logic [swa_pkg::SliceW:0]   w_diff;

    // shifted remainder slice and trial subtract
    always_comb begin
        w_sh   = {r_rem[swa_pkg::SliceW-2:0], i_rem_in};
        w_diff = {1'b0, w_sh} - {1'b0, i_dvs} - {{swa_pkg::SliceW{1'b0}}, i_lo.borrow};
        o_hi.borrow    = w_diff[swa_pkg::SliceW];
        o_hi.shift_bit = r_dq[swa_pkg::SliceW-1];
        o_rem_out      = r_rem[swa_pkg::SliceW-1];
        n_rem = r_rem;
        n_dq  = r_dq;
        if (i_ctl.load) begin
            n_rem = '0;
            n_dq  = i_dvd_load;
        end else if (i_ctl.step) begin
            n_rem = i_commit ? w_diff[swa_pkg::SliceW-1:0] : w_sh;
            n_dq  = {r_dq[swa_pkg::SliceW-2:0], i_lo.shift_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
    end

    assign o_rem = r_rem;
    assign o_quo = r_dq;

endmodule

FILE: hw/rtl/swa_div_chain.sv
// ----------------------------------------------------------------------------
// swa_div_chain: row of divider cells
// Links the slices and decides the quotient bit from the top borrow.
// ----------------------------------------------------------------------------
module swa_div_chain (
    input  logic                        i_clk,
    input  swa_pkg::t_cell_ctl          i_ctl,
    input  logic [swa_pkg::DataW-1:0]   i_dividend,
    input  logic [swa_pkg::DataW-1:0]   i_divisor,
    output logic [swa_pkg::DataW-1:0]   o_quo,
    output logic [swa_pkg::DataW-1:0]   o_rem
);

    swa_pkg::t_link w_link [swa_pkg::NCells+1];
    logic [swa_pkg::NCells:0] w_rbit;
    logic w_commit;

    // quotient bit enters at the bottom; remainder carry out of the top
    assign w_link[0].shift_bit = w_commit;
    assign w_link[0].borrow    = 1'b0;
    assign w_rbit[0]           = o_quo[swa_pkg::DataW-1];
    assign w_commit = w_rbit[swa_pkg::NCells] | ~w_link[swa_pkg::NCells].borrow;

    for (genvar g = 0; g < swa_pkg::NCells; g++) begin : g_cell
        swa_div_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_commit   (w_commit),
            .i_dvd_load (i_dividend[g*swa_pkg::SliceW +: swa_pkg::SliceW]),
            .i_dvs      (i_divisor[g*swa_pkg::SliceW +: swa_pkg::SliceW]),
            .i_lo       (w_link[g]),
            .i_rem_in   (w_rbit[g]),
            .o_hi       (w_link[g+1]),
            .o_rem_out  (w_rbit[g+1]),
            .o_rem      (o_rem[g*swa_pkg::SliceW +: swa_pkg::SliceW]),
            .o_quo      (o_quo[g*swa_pkg::SliceW +: swa_pkg::SliceW])
        );
    end

endmodule

FILE: tb/tb_split_word_64bit_alu.sv
// ----------------------------------------------------------------------------
// tb_split_word_64bit_alu: self-checking bench for the split-word 64-bit ALU
// Drives directed corner operands and random operations through the valid/ready
// input channel, predicts each result in the bench and checks every output
// transaction in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_split_word_64bit_alu;

    // Expected result of one transaction
    typedef struct {
        logic [swa_pkg::DataW-1:0] result;
        logic [swa_pkg::CmpW-1:0]  sign;
    } t_alu_expect;

    // Scoreboard: predicts results of accepted inputs, checks outputs in order
    class t_alu_scoreboard;
        t_alu_expect pending[$];
        int          errors;

        function void note_input(logic [swa_pkg::ActW-1:0] act,
                                 logic [swa_pkg::DataW-1:0] a,
                                 logic [swa_pkg::DataW-1:0] b);
            t_alu_expect e;
            logic [swa_pkg::DataW-1:0] quot, rem;
            int               order;
            bit               carry;
            // signed order of a against b
            if ($signed(a) > $signed(b)) order = 1;
            else if ($signed(a) < $signed(b)) order = -1;
            else order = 0;
            // restoring shift-subtract division on unsigned patterns
            quot = '0;
            rem  = '0;
            if (b != '0) begin
                for (int i = swa_pkg::DataW - 1; i >= 0; i--) begin
                    carry = rem[swa_pkg::DataW-1];
                    rem   = {rem[swa_pkg::DataW-2:0], a[i]};
                    quot  = quot << 1;
                    if (carry || rem >= b) begin
                        rem     = rem - b;
                        quot[0] = 1'b1;
                    end
                end
            end
            case (act)
                swa_pkg::ACT_ADD: e.result = a + b;
                swa_pkg::ACT_SUB: e.result = a - b;
                swa_pkg::ACT_MUL: e.result = a * b;
                swa_pkg::ACT_CMP: e.result = (order < 0) ? '1 : swa_pkg::DataW'(order);
                swa_pkg::ACT_DIV: e.result = (b == '0) ? a : quot;
                swa_pkg::ACT_MOD: e.result = (b == '0) ? a : rem;
                default: e.result = '0;
            endcase
            e.sign = (order < 0) ? 2'b11 : swa_pkg::CmpW'(order);
            pending.push_back(e);
        endfunction

        function void check_output(logic [swa_pkg::DataW-1:0] res,
                                   logic [swa_pkg::CmpW-1:0] sgn);
            t_alu_expect e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h sign %b", $time, res, sgn);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.result) begin
                $display("%0t: result expected %h actual %h", $time, e.result, res);
                errors++;
            end
            if (sgn !== e.sign) begin
                $display("%0t: compare_sign expected %b actual %b", $time, e.sign, sgn);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [swa_pkg::ActW-1:0]         i_action = '0;
    logic signed [swa_pkg::DataW-1:0] i_a_value = '0;
    logic signed [swa_pkg::DataW-1:0] i_b_value = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic signed [swa_pkg::DataW-1:0] o_result_value;
    logic signed [swa_pkg::CmpW-1:0]  o_compare_sign;

    t_alu_scoreboard sb = new();
    bit              hold_off = 1'b0;

    split_word_64bit_alu dut (.*);

    always #5 i_clk = ~i_clk;

    // Random 64-bit operand biased toward corner values
    function automatic logic [swa_pkg::DataW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '0;
            3: return '1;
            4: return swa_pkg::DataW'($urandom_range(0, 20));
            5: return {{32{1'b0}}, 32'($urandom)};
            6: return {32'hffff_ffff, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Send one input transaction, after a random gap when gaps is set
    task automatic send_op(logic [swa_pkg::ActW-1:0] act, logic [swa_pkg::DataW-1:0] a,
                           logic [swa_pkg::DataW-1:0] b, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_a_value <= a;
        i_b_value <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(act, a, b);
    endtask

    // Output side: random stalls, plus long hold-offs while hold_off is set
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (hold_off) stall = 400;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_output(o_result_value, o_compare_sign);
        end
    end

    // Stimulus and end of run
    initial begin
        logic [swa_pkg::DataW-1:0] corner[6];
        int               waited;
        corner = '{64'h0, 64'h1, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                   64'h7fff_ffff_ffff_ffff, 64'h0000_0001_0000_0000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // every action, including unused codes, on corner operands
        for (int op = 0; op < 8; op++) begin
            send_op(swa_pkg::ActW'(op), corner[op % 6], corner[(op + 3) % 6], 1'b0);
        end
        send_op(swa_pkg::ACT_DIV, 64'd12345, '0, 1'b0);           // zero divisor
        send_op(swa_pkg::ACT_MOD, 64'h8000_0000_0000_0000, '0, 1'b0);
        send_op(swa_pkg::ACT_DIV, '1, 64'd3, 1'b0);              // negative as unsigned
        send_op(swa_pkg::ACT_MOD, '1, 64'h8000_0000_0000_0001, 1'b0);
        send_op(swa_pkg::ACT_DIV, 64'h8000_0000_0000_0000, '1, 1'b0);
        send_op(swa_pkg::ACT_MUL, '1, '1, 1'b0);
        send_op(swa_pkg::ACT_MUL, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 1'b0);
        send_op(swa_pkg::ACT_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1, 1'b0);
        send_op(swa_pkg::ACT_SUB, 64'h8000_0000_0000_0000, 64'd1, 1'b0);
        send_op(swa_pkg::ACT_CMP, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0);
        send_op(swa_pkg::ACT_CMP, 64'd5, 64'd5, 1'b0);
        send_op(swa_pkg::ACT_CMP, 64'd6, 64'd5, 1'b0);
        // long receiver hold-offs while inputs are offered with no gaps
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_op(swa_pkg::ActW'(i), pick_operand(), pick_operand(), 1'b0);
        end
        hold_off = 1'b0;
        // random part
        for (int i = 0; i < 450; i++) begin
            send_op(($urandom_range(0, 15) == 0) ? swa_pkg::ActW'($urandom_range(6, 7))
                                                 : swa_pkg::ActW'($urandom_range(0, 5)),
                    pick_operand(), pick_operand(), 1'b1);
        end
        i_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Timeout
    initial begin
        #3ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
